// File: design/jts_pkg.sv
// ---------------------------------------------------------------------------
// jts_pkg: shared types and constants of the JSON token scanner
// Request and result layouts, byte classes, scan modes and sequencer states.
// ---------------------------------------------------------------------------
package jts_pkg;

    // Default table and text sizes
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int TEXT_MAX_DEF    = 65535;

    // Fixed field widths of the stream payloads
    localparam int REQ_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int INDEX_W      = 6;
    localparam int LIMIT_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int KIND_W       = 2;
    localparam int START_OUT_W  = 17;
    localparam int END_OUT_W    = 18;
    localparam int PARENT_OUT_W = 7;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;
    localparam int S_PAD_W   = S_TDATA_W - BYTE_W - INDEX_W;
    localparam int M_PAD_W   = M_TDATA_W - COUNT_W - 1 - KIND_W - START_OUT_W
                               - END_OUT_W - PARENT_OUT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Entry kinds
    localparam logic [KIND_W-1:0] KIND_OBJECT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARRAY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRING    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PRIMITIVE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TEXT    = 2'd0,
        REQ_EOT     = 2'd1,
        REQ_READ    = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CLS_OPEN_OBJ,
        CLS_OPEN_ARR,
        CLS_CLOSE,
        CLS_QUOTE,
        CLS_SEP,
        CLS_COLON,
        CLS_OTHER
    } byte_class_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_PRIM
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CHK,
        ST_READ_DATA
    } state_t;

    // Classified request passed from the front end to the back end
    typedef struct packed {
        req_t               req;
        byte_class_t        cls;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0]            status;
        logic [COUNT_W-1:0]             token_count;
        logic                           entry_valid;
        logic [KIND_W-1:0]              entry_type;
        logic signed [START_OUT_W-1:0]  entry_start;
        logic signed [END_OUT_W-1:0]    entry_end;
        logic signed [PARENT_OUT_W-1:0] entry_parent;
    } result_t;

endpackage

// File: design/json_token_scanner_top.sv
// ---------------------------------------------------------------------------
// json_token_scanner_top: streaming JSON tokenizer
// Builds a token table from JSON text one byte per request and reads
// entries back on request.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    s_tuser req_type, s_tdata text+index
//  m_*       out        m_tvalid/m_tready    m_tuser status, m_tdata entry data
//  cfg_*     in         cfg_wr_en            cfg_wr_data token_limit
//
//  A request passes a two-entry queue before it reaches the sequencer.
//  Text, end-of-text and restart requests sustain one request per cycle
//  while results are taken; a read also passes the read data state, and a
//  closing bracket passes the search read and check states for each entry
//  the backward search visits through the single table read port.
//  Reset is synchronous and active low; no table clearing pass follows it.
//  A stalled result register blocks the sequencer, while the queue keeps
//  taking requests until it holds two.
//
module json_token_scanner_top
    import jts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] text_byte, [13:8] token_index
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [6:0] token_count, [7] entry_valid, [9:8] entry_type,
    // [26:10] entry_start, [44:27] entry_end, [51:45] entry_parent
    output logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]  m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data
);

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    result_t res;

    // Intake and classification
    jts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (req_t'(s_tuser)),
        .text_byte   (s_tdata[BYTE_W-1:0]),
        .token_index (s_tdata[BYTE_W+INDEX_W-1:BYTE_W]),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Table sequencer
    jts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (m_tvalid),
        .res         (res),
        .res_ready   (m_tready)
    );

    // Result packing, first field in the lowest bits
    assign m_tuser = res.status;
    assign m_tdata = {{M_PAD_W{1'b0}}, res.entry_parent, res.entry_end, res.entry_start,
                      res.entry_type, res.entry_valid, res.token_count};

endmodule

// File: design/jts_front.sv
// ---------------------------------------------------------------------------
// jts_front: request intake and byte classification
// Accepts requests, sorts text bytes into classes and buffers them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module jts_front
    import jts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  req_t               req_type,
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic [INDEX_W-1:0] token_index,
    output logic               cmd_valid,
    output cmd_t               cmd,
    input  logic               cmd_pop
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    cmd_t       queue_reg [2];
    cmd_t       cmd_in;
    logic       push;

    // Byte class, independent of the scan mode
    function automatic byte_class_t classify(input logic [BYTE_W-1:0] c);
        byte_class_t cls;
        case (c)
            8'h7B:                                 cls = CLS_OPEN_OBJ;
            8'h5B:                                 cls = CLS_OPEN_ARR;
            8'h7D, 8'h5D:                          cls = CLS_CLOSE;
            8'h22:                                 cls = CLS_QUOTE;
            8'h2C, 8'h20, 8'h09, 8'h0D, 8'h0A, 8'h00: cls = CLS_SEP;
            8'h3A:                                 cls = CLS_COLON;
            default:                               cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    // Build the queued command
    always_comb begin
        cmd_in.req   = req_type;
        cmd_in.cls   = classify(text_byte);
        cmd_in.index = token_index;
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: design/jts_back.sv
// ---------------------------------------------------------------------------
// jts_back: token table sequencer
// Executes classified requests against the token table, runs the backward
// search for closing brackets and holds the result register.
// ---------------------------------------------------------------------------
module jts_back
    import jts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_pop,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    output logic               res_valid,
    output result_t            res,
    input  logic               res_ready
);

    // Table and text sizes are fixed to the package defaults.
    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int TEXT_MAX    = TEXT_MAX_DEF;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W  = $clog2(TEXT_MAX + 1);
    localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int INFO_W = KIND_W + POS_W + 1 + IDX_W;
    localparam int ENDM_W = POS_W + 1;

    // Control state
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic               full_reg, full_next;
    logic [CNT_W-1:0]   next_entry_reg, next_entry_next;
    logic               open_top_reg, open_top_next;
    logic [IDX_W-1:0]   open_idx_reg, open_idx_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    // Table memories and their read registers
    logic [INFO_W-1:0] info_mem [TABLE_DEPTH];
    logic [ENDM_W-1:0] end_mem  [TABLE_DEPTH];
    logic [INFO_W-1:0] info_rd_reg;
    logic [ENDM_W-1:0] end_rd_reg;

    logic              info_we, end_we;
    logic [IDX_W-1:0]  info_waddr, end_waddr, mem_raddr;
    logic [INFO_W-1:0] info_wdata;
    logic [ENDM_W-1:0] end_wdata;

    // Decode signals
    logic             can_start, pos_ovf, table_hit, need_search, found;
    logic             load_out, ovf_flag;
    logic [IDX_W-1:0] last_idx;
    logic [KIND_W-1:0] new_kind;
    logic [POS_W-1:0]  new_start;
    result_t           res_comb;

    logic [KIND_W-1:0] rd_kind;
    logic [POS_W-1:0]  rd_start;
    logic              rd_top;
    logic [IDX_W-1:0]  rd_parent;
    logic              rd_open;
    logic [POS_W-1:0]  rd_end;

    assign rd_kind   = info_rd_reg[INFO_W-1 -: KIND_W];
    assign rd_start  = info_rd_reg[IDX_W+POS_W -: POS_W];
    assign rd_top    = info_rd_reg[IDX_W];
    assign rd_parent = info_rd_reg[IDX_W-1:0];
    assign rd_open   = end_rd_reg[POS_W];
    assign rd_end    = end_rd_reg[POS_W-1:0];

    // Shared decisions for the sequencer
    always_comb begin
        can_start   = (state_reg == ST_IDLE) && cmd_valid && (!out_valid_reg || res_ready);
        pos_ovf     = (pos_reg >= POS_W'(TEXT_MAX));
        table_hit   = (CMP_W'(next_entry_reg) >= CMP_W'(limit_reg)) ||
                      (next_entry_reg >= CNT_W'(TABLE_DEPTH));
        need_search = (cmd.req == REQ_TEXT) && !full_reg && !pos_ovf &&
                      (cmd.cls == CLS_CLOSE) && (mode_reg != MODE_STRING) &&
                      (next_entry_reg != '0);
        found       = rd_open;
        last_idx    = IDX_W'(next_entry_reg - CNT_W'(1));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (can_start) begin
                    if (cmd.req == REQ_READ) begin
                        state_next = ST_READ_DATA;
                    end else if (need_search) begin
                        state_next = ST_SEARCH_RD;
                    end
                end
            end
            ST_SEARCH_RD: begin
                state_next = ST_SEARCH_CHK;
            end
            ST_SEARCH_CHK: begin
                if (found || (scan_reg == '0)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SEARCH_RD;
                end
            end
            ST_READ_DATA: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, table writes and result load
    always_comb begin
        mode_next       = mode_reg;
        full_next       = full_reg;
        next_entry_next = next_entry_reg;
        open_top_next   = open_top_reg;
        open_idx_next   = open_idx_reg;
        pos_next        = pos_reg;
        scan_next       = scan_reg;
        rd_ok_next      = rd_ok_reg;
        limit_next      = cfg_wr_en ? cfg_wr_data : limit_reg;
        cmd_pop         = 1'b0;
        load_out        = 1'b0;
        ovf_flag        = 1'b0;
        info_we         = 1'b0;
        info_waddr      = IDX_W'(next_entry_reg);
        end_we          = 1'b0;
        end_waddr       = last_idx;
        end_wdata       = {1'b0, pos_reg};
        mem_raddr       = scan_reg;
        new_kind        = KIND_PRIMITIVE;
        new_start       = pos_reg;

        case (cmd.cls)
            CLS_OPEN_OBJ: new_kind = KIND_OBJECT;
            CLS_OPEN_ARR: new_kind = KIND_ARRAY;
            CLS_QUOTE: begin
                new_kind  = KIND_STRING;
                new_start = pos_reg + POS_W'(1);
            end
            default:      new_kind = KIND_PRIMITIVE;
        endcase
        info_wdata = {new_kind, new_start, open_top_reg, open_idx_reg};

        case (state_reg)
            ST_IDLE: begin
                mem_raddr = IDX_W'(cmd.index);
                if (can_start) begin
                    cmd_pop  = 1'b1;
                    load_out = (cmd.req != REQ_READ) && !need_search;
                    case (cmd.req)
                        REQ_TEXT: begin
                            if (!full_reg && pos_ovf) begin
                                ovf_flag = 1'b1;
                            end else if (!full_reg) begin
                                case (mode_reg)
                                    MODE_STRING: begin
                                        pos_next = pos_reg + POS_W'(1);
                                        if (cmd.cls == CLS_QUOTE) begin
                                            end_we    = 1'b1;
                                            mode_next = MODE_NORMAL;
                                        end
                                    end
                                    MODE_PRIM: begin
                                        pos_next = pos_reg + POS_W'(1);
                                        if (cmd.cls inside {CLS_SEP, CLS_CLOSE}) begin
                                            end_we    = 1'b1;
                                            mode_next = MODE_NORMAL;
                                        end
                                    end
                                    default: begin
                                        if (cmd.cls inside {CLS_OPEN_OBJ, CLS_OPEN_ARR,
                                                            CLS_QUOTE, CLS_OTHER}) begin
                                            if (table_hit) begin
                                                full_next = 1'b1;
                                            end else begin
                                                info_we         = 1'b1;
                                                end_we          = 1'b1;
                                                end_waddr       = IDX_W'(next_entry_reg);
                                                end_wdata       = {1'b1, pos_reg};
                                                next_entry_next = next_entry_reg + CNT_W'(1);
                                                pos_next        = pos_reg + POS_W'(1);
                                                if (cmd.cls == CLS_QUOTE) begin
                                                    mode_next = MODE_STRING;
                                                end else if (cmd.cls == CLS_OTHER) begin
                                                    mode_next = MODE_PRIM;
                                                end else begin
                                                    open_top_next = 1'b0;
                                                    open_idx_next = IDX_W'(next_entry_reg);
                                                end
                                            end
                                        end else begin
                                            pos_next = pos_reg + POS_W'(1);
                                        end
                                    end
                                endcase
                            end
                            scan_next = last_idx;
                        end
                        REQ_EOT: begin
                            if (!full_reg) begin
                                end_we    = (mode_reg == MODE_PRIM);
                                mode_next = MODE_NORMAL;
                            end
                        end
                        REQ_READ: begin
                            rd_ok_next = (CMP_W'(cmd.index) < CMP_W'(next_entry_reg));
                        end
                        default: begin
                            next_entry_next = '0;
                            open_top_next   = 1'b1;
                            open_idx_next   = '0;
                            pos_next        = '0;
                            mode_next       = MODE_NORMAL;
                            full_next       = 1'b0;
                        end
                    endcase
                end
            end
            ST_SEARCH_CHK: begin
                // The position already points past the closing bracket
                if (found) begin
                    end_we        = 1'b1;
                    end_waddr     = scan_reg;
                    end_wdata     = {1'b0, pos_reg};
                    open_top_next = rd_top;
                    open_idx_next = rd_parent;
                    load_out      = 1'b1;
                end else if (scan_reg == '0) begin
                    load_out = 1'b1;
                end else begin
                    scan_next = scan_reg - IDX_W'(1);
                end
            end
            ST_READ_DATA: begin
                load_out = 1'b1;
            end
            default: begin
                mem_raddr = scan_reg;
            end
        endcase
    end

    // Result assembly
    always_comb begin
        if (full_next) begin
            res_comb.status = STATUS_FULL;
        end else if (ovf_flag) begin
            res_comb.status = STATUS_OVERFLOW;
        end else begin
            res_comb.status = STATUS_OK;
        end
        res_comb.token_count = COUNT_W'(next_entry_next);
        if ((state_reg == ST_READ_DATA) && rd_ok_reg) begin
            res_comb.entry_valid  = 1'b1;
            res_comb.entry_type   = rd_kind;
            res_comb.entry_start  = START_OUT_W'(rd_start);
            res_comb.entry_end    = rd_open ? '1 : END_OUT_W'(rd_end);
            res_comb.entry_parent = rd_top ? '1 : PARENT_OUT_W'(rd_parent);
        end else begin
            res_comb.entry_valid  = 1'b0;
            res_comb.entry_type   = KIND_OBJECT;
            res_comb.entry_start  = '1;
            res_comb.entry_end    = '1;
            res_comb.entry_parent = '1;
        end
        out_valid_next = load_out ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_NORMAL;
            full_reg       <= 1'b0;
            next_entry_reg <= '0;
            open_top_reg   <= 1'b1;
            open_idx_reg   <= '0;
            pos_reg        <= '0;
            limit_reg      <= LIMIT_RESET;
            scan_reg       <= '0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            full_reg       <= full_next;
            next_entry_reg <= next_entry_next;
            open_top_reg   <= open_top_next;
            open_idx_reg   <= open_idx_next;
            pos_reg        <= pos_next;
            limit_reg      <= limit_next;
            scan_reg       <= scan_next;
            rd_ok_reg      <= rd_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= res_comb;
        end
    end

    // Token table: one write and one registered read per memory per cycle
    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[info_waddr] <= info_wdata;
        end
        if (end_we) begin
            end_mem[end_waddr] <= end_wdata;
        end
        info_rd_reg <= info_mem[mem_raddr];
        end_rd_reg  <= end_mem[mem_raddr];
    end

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!out_valid_reg || res_ready))
        else $error("result register loaded while a result is pending");

    // The backward search stays inside the allocated part of the table.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH_RD) |-> (CMP_W'(scan_reg) < CMP_W'(next_entry_reg)))
        else $error("search index beyond allocated entries");

    // The allocation count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_entry_reg <= CNT_W'(TABLE_DEPTH))
        else $error("token count beyond table depth");

    // The table can only fill up while scanning in normal mode.
    a_full_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (mode_reg == MODE_NORMAL))
        else $error("full flag set outside normal mode");

    // Only the idle state takes a request from the queue.
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == ST_IDLE) && cmd_valid)
        else $error("request taken outside the idle state");

endmodule
